### design/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

    // Field widths
    localparam int ID_W      = 8;
    localparam int POS_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 5;
    localparam int IN_DATA_W = 24;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    // Defaults
    localparam int DEF_MAX_MOTORS   = 16;
    localparam int DEF_MOTOR_COUNT  = 6;
    localparam int DEF_TARGET_REG   = 42;
    localparam int QUEUE_DEPTH      = 2;

    // Packet constants
    localparam logic [BYTE_W-1:0] HDR_BYTE         = 8'hFF;
    localparam logic [BYTE_W-1:0] BCAST_ID         = 8'hFE;
    localparam logic [BYTE_W-1:0] SYNC_WRITE_INST  = 8'h83;
    localparam logic [BYTE_W-1:0] ENTRY_DATA_BYTES = 8'h02;
    localparam int               LEN_BASE        = 4;
    localparam int               LEN_PER_ENTRY   = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOTOR_COUNT = 1'b0,
        CFG_TARGET_REG  = 1'b1
    } t_cfg_idx;

    // One classified entry handed from front to back
    typedef struct packed {
        logic              first;
        logic              last;
        logic [BYTE_W-1:0] length;
        logic [BYTE_W-1:0] target;
        logic [ID_W-1:0]   id;
        logic [POS_W-1:0]  pos;
    } t_sfr_cmd;

    // Byte sequencer steps
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HDR0,
        ST_HDR1,
        ST_BCAST,
        ST_LEN,
        ST_INST,
        ST_ADDR,
        ST_DLEN,
        ST_ID,
        ST_POS_LO,
        ST_POS_HI,
        ST_CSUM
    } t_sfr_step;

endpackage

`default_nettype wire

### design/sfr_front.sv
`default_nettype none

module sfr_front #(
    parameter int MAX_MOTORS = sfr_pkg::DEF_MAX_MOTORS
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire  [sfr_pkg::ID_W-1:0]      i_id,
    input  wire  [sfr_pkg::POS_W-1:0]     i_pos,
    input  wire  [sfr_pkg::COUNT_W-1:0]   i_motor_count,
    input  wire  [sfr_pkg::BYTE_W-1:0]    i_target_reg,
    output logic                          o_push,
    input  wire                           i_queue_full,
    output sfr_pkg::t_sfr_cmd             o_cmd
);
    import sfr_pkg::*;

    localparam int CW = $clog2(MAX_MOTORS + 1);

    logic [CW-1:0] r_idx;
    logic [CW-1:0] n_idx;
    logic [CW-1:0] eff_n;
    logic [CW:0]   idx_inc;
    logic          is_last;

    // clamp count to 1..MAX_MOTORS
    always_comb begin
        if (i_motor_count == '0) begin
            eff_n = CW'(1);
        end else if (int'(i_motor_count) > MAX_MOTORS) begin
            eff_n = CW'(MAX_MOTORS);
        end else begin
            eff_n = CW'(i_motor_count);
        end
    end

    assign idx_inc = {1'b0, r_idx} + (CW+1)'(1);
    assign is_last = idx_inc >= {1'b0, eff_n};
    assign n_idx   = is_last ? '0 : idx_inc[CW-1:0];

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    always_comb begin
        o_cmd.first  = (r_idx == '0);
        o_cmd.last   = is_last;
        o_cmd.length = BYTE_W'(LEN_BASE + LEN_PER_ENTRY * int'(eff_n));
        o_cmd.target = i_target_reg;
        o_cmd.id     = i_id;
        o_cmd.pos    = i_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (o_push) begin
            r_idx <= n_idx;
        end
    end

endmodule

`default_nettype wire

### design/sfr_queue.sv
`default_nettype none

module sfr_queue #(
    parameter int DEPTH = sfr_pkg::QUEUE_DEPTH
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  sfr_pkg::t_sfr_cmd  i_cmd,
    output logic               o_full,
    input  wire                i_pop,
    output logic               o_valid,
    output sfr_pkg::t_sfr_cmd  o_cmd
);
    import sfr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_sfr_cmd        r_mem [DEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (int'(r_wptr) == DEPTH - 1) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (int'(r_rptr) == DEPTH - 1) ? '0 : r_rptr + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### design/sfr_back.sv
`default_nettype none

module sfr_back (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_q_valid,
    input  sfr_pkg::t_sfr_cmd           i_q_cmd,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic [sfr_pkg::BYTE_W-1:0]  o_byte,
    output logic                        o_last
);
    import sfr_pkg::*;

    t_sfr_step           r_step;
    t_sfr_step           n_step;
    t_sfr_cmd            r_cmd;
    logic [BYTE_W-1:0]   r_sum;
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_last;

    logic                out_free;
    logic                emit;
    logic                done_item;
    logic                load;
    logic                sum_it;
    logic [BYTE_W-1:0]   cur_byte;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        emit      = (r_step != ST_IDLE) && out_free;
        cur_byte  = '0;
        sum_it    = 1'b1;
        unique case (r_step)
            ST_IDLE: begin
                sum_it = 1'b0;
            end
            ST_HDR0, ST_HDR1: begin
                cur_byte = HDR_BYTE;
                sum_it   = 1'b0;
            end
            ST_BCAST:  cur_byte = BCAST_ID;
            ST_LEN:    cur_byte = r_cmd.length;
            ST_INST:   cur_byte = SYNC_WRITE_INST;
            ST_ADDR:   cur_byte = r_cmd.target;
            ST_DLEN:   cur_byte = ENTRY_DATA_BYTES;
            ST_ID:     cur_byte = r_cmd.id;
            ST_POS_LO: cur_byte = r_cmd.pos[7:0];
            ST_POS_HI: cur_byte = r_cmd.pos[15:8];
            ST_CSUM: begin
                cur_byte = ~r_sum;
                sum_it   = 1'b0;
            end
            default: begin
                sum_it = 1'b0;
            end
        endcase

        done_item = emit && (((r_step == ST_POS_HI) && !r_cmd.last) || (r_step == ST_CSUM));
        load      = i_q_valid && ((r_step == ST_IDLE) || done_item);
        o_q_pop   = load;

        n_step = r_step;
        if (load) begin
            n_step = i_q_cmd.first ? ST_HDR0 : ST_ID;
        end else if (done_item) begin
            n_step = ST_IDLE;
        end else if (emit) begin
            unique case (r_step)
                ST_HDR0:   n_step = ST_HDR1;
                ST_HDR1:   n_step = ST_BCAST;
                ST_BCAST:  n_step = ST_LEN;
                ST_LEN:    n_step = ST_INST;
                ST_INST:   n_step = ST_ADDR;
                ST_ADDR:   n_step = ST_DLEN;
                ST_DLEN:   n_step = ST_ID;
                ST_ID:     n_step = ST_POS_LO;
                ST_POS_LO: n_step = ST_POS_HI;
                ST_POS_HI: n_step = ST_CSUM;
                default:   n_step = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_q_cmd;
        end
        if (emit) begin
            r_out_byte <= cur_byte;
            r_out_last <= (r_step == ST_CSUM);
            // sum restarts at the head of each packet
            if (r_step == ST_HDR0) begin
                r_sum <= '0;
            end else if (sum_it) begin
                r_sum <= r_sum + cur_byte;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

endmodule

`default_nettype wire

### design/servo_sync_write_framer.sv
`default_nettype none

// Sync-write packet framer for a half-duplex servo bus. Each input transfer
// carries one motor entry (servo id, 16-bit goal position); the block emits
// the packet one byte per output transfer. The first entry of a packet is
// preceded by the head FF FF FE <4+3n> 83 <target_register> 02, every entry
// gives id, position low, position high, and the entry that completes the
// configured count is followed by the checksum byte (tlast high), the
// inverted low byte of the sum of everything after the two FF bytes.
// Rate: the byte sequencer emits one byte per clock while entries are queued
// and the output is ready; an entry gives 3 bytes, 10 when it opens a packet,
// plus the checksum byte. A 2-entry command queue sits between the input
// classifier and the sequencer, so the input side takes new entries while
// earlier bytes are still draining or stalled. motor_count is clamped to
// 1..MAX_MOTORS. Configuration is taken in any cycle (ready tied high) and
// should only be written while no packet is in flight.
module servo_sync_write_framer #(
    parameter int MAX_MOTORS = sfr_pkg::DEF_MAX_MOTORS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // input stream: [7:0] servo_id, [23:8] goal_pos
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    input  wire  [sfr_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // output stream: [7:0] tx_byte; tlast = end_of_packet
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    output logic [sfr_pkg::BYTE_W-1:0]       o_m_tdata,
    output logic                             o_m_tlast,
    // configuration write: index 0 motor_count, 1 target_register
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [sfr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [sfr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sfr_pkg::*;

    logic [COUNT_W-1:0] r_motor_count;
    logic [BYTE_W-1:0]  r_target_reg;

    t_sfr_cmd  front_cmd;
    t_sfr_cmd  q_cmd;
    logic      front_push;
    logic      q_full;
    logic      q_valid;
    logic      q_pop;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_count <= COUNT_W'(DEF_MOTOR_COUNT);
            r_target_reg  <= BYTE_W'(DEF_TARGET_REG);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MOTOR_COUNT: r_motor_count <= i_cfg_data[COUNT_W-1:0];
                CFG_TARGET_REG:  r_target_reg  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: tracks entry position in the packet, tags first/last, length
    sfr_front #(
        .MAX_MOTORS (MAX_MOTORS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_id          (i_s_tdata[ID_W-1:0]),
        .i_pos         (i_s_tdata[ID_W +: POS_W]),
        .i_motor_count (r_motor_count),
        .i_target_reg  (r_target_reg),
        .o_push        (front_push),
        .i_queue_full  (q_full),
        .o_cmd         (front_cmd)
    );

    sfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // back: byte sequencer, running checksum and output register
    sfr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_byte    (o_m_tdata),
        .o_last    (o_m_tlast)
    );

endmodule

`default_nettype wire

### design/sfr_checker.sv
`default_nettype none

module sfr_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              o_cfg_ready,
    input  wire                              o_m_tvalid,
    input  wire                              i_m_tready,
    input  wire  [sfr_pkg::BYTE_W-1:0]       o_m_tdata,
    input  wire                              o_m_tlast
);
    import sfr_pkg::*;

    // high while the next output byte must open a packet
    logic r_pkt_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_start <= 1'b1;
        end else if (o_m_tvalid && i_m_tready) begin
            r_pkt_start <= o_m_tlast;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("stalled output changed");

    a_pkt_opens_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_pkt_start) |-> (o_m_tdata == HDR_BYTE && !o_m_tlast))
        else $error("packet does not open with header byte");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind servo_sync_write_framer sfr_checker u_sfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_cfg_ready (o_cfg_ready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tlast   (o_m_tlast)
);

`default_nettype wire
